// ----- hw/rtl/jbpn_pkg.sv -----
// Shared constants and types for the playout jitter buffer.
`timescale 1ns / 1ps
package jbpn_pkg;
    localparam int WINDOW_DEF       = 32;
    localparam int MAX_ADVANCES_DEF = 62;

    localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;

    localparam logic [2:0] K_ACC   = 3'd0;
    localparam logic [2:0] K_STALE = 3'd1;
    localparam logic [2:0] K_OOW   = 3'd2;
    localparam logic [2:0] K_PLAY  = 3'd3;
    localparam logic [2:0] K_LOST  = 3'd4;
    localparam logic [2:0] K_NACK  = 3'd5;
    localparam logic [2:0] K_DONE  = 3'd6;

    localparam logic [2:0] R_FIRST  = 3'd0;
    localparam logic [2:0] R_PERIOD = 3'd1;
    localparam logic [2:0] R_RTT    = 3'd2;
    localparam logic [2:0] R_IVL    = 3'd3;
    localparam logic [2:0] R_MAXN   = 3'd4;
    localparam logic [2:0] R_DUPP   = 3'd5;
    localparam logic [2:0] R_DUPQ   = 3'd6;
    localparam logic [2:0] R_CAP    = 3'd7;

    typedef struct packed {
        logic [47:0] first_deadline;
        logic [19:0] frame_period;
        logic [19:0] nack_rtt;
        logic [19:0] nack_interval;
        logic [3:0]  max_nacks;
        logic [15:0] dup_len;
        logic [15:0] dup_floor;
        logic [19:0] wait_cap;
    } t_cfg;

    typedef struct packed {
        logic        wr;
        logic [2:0]  idx;
    } t_cfg_evt;
endpackage

// ----- hw/rtl/jbpn_regs.sv -----
// APB register file for the playout jitter buffer.
`timescale 1ns / 1ps
module jbpn_regs (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [5:0]            paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready,
    output jbpn_pkg::t_cfg        o_cfg,
    output jbpn_pkg::t_cfg_evt    o_evt
);
    jbpn_pkg::t_cfg r_cfg;
    logic           w_wr;
    logic [2:0]     w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[5:3];
    assign o_cfg  = r_cfg;
    assign o_evt  = '{wr: w_wr, idx: w_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_deadline <= 48'd0;
            r_cfg.frame_period   <= 20'd20000;
            r_cfg.nack_rtt       <= 20'd90000;
            r_cfg.nack_interval  <= 20'd20000;
            r_cfg.max_nacks      <= 4'd2;
            r_cfg.dup_len        <= 16'd1500;
            r_cfg.dup_floor      <= 16'd1407;
            r_cfg.wait_cap       <= 20'd50000;
        end else if (w_wr) begin
            unique case (w_idx)
                jbpn_pkg::R_FIRST:  r_cfg.first_deadline <= pwdata[47:0];
                jbpn_pkg::R_PERIOD: r_cfg.frame_period   <= pwdata[19:0];
                jbpn_pkg::R_RTT:    r_cfg.nack_rtt       <= pwdata[19:0];
                jbpn_pkg::R_IVL:    r_cfg.nack_interval  <= pwdata[19:0];
                jbpn_pkg::R_MAXN:   r_cfg.max_nacks      <= pwdata[3:0];
                jbpn_pkg::R_DUPP:   r_cfg.dup_len        <= pwdata[15:0];
                jbpn_pkg::R_DUPQ:   r_cfg.dup_floor      <= pwdata[15:0];
                jbpn_pkg::R_CAP:    r_cfg.wait_cap       <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            jbpn_pkg::R_FIRST:  prdata = {16'd0, r_cfg.first_deadline};
            jbpn_pkg::R_PERIOD: prdata = {44'd0, r_cfg.frame_period};
            jbpn_pkg::R_RTT:    prdata = {44'd0, r_cfg.nack_rtt};
            jbpn_pkg::R_IVL:    prdata = {44'd0, r_cfg.nack_interval};
            jbpn_pkg::R_MAXN:   prdata = {60'd0, r_cfg.max_nacks};
            jbpn_pkg::R_DUPP:   prdata = {48'd0, r_cfg.dup_len};
            jbpn_pkg::R_DUPQ:   prdata = {48'd0, r_cfg.dup_floor};
            jbpn_pkg::R_CAP:    prdata = {44'd0, r_cfg.wait_cap};
            default:            prdata = 64'd0;
        endcase
    end
endmodule

// ----- hw/rtl/jitter_buffer_playout_nack.sv -----
// Top level of the playout jitter buffer with NACK generation.
// An arrival's result is registered in S_ARR once the output register is free.
// A poll passes S_RD and S_STEP for each play/lost step, then S_N1, S_N2 and S_N3
// (skipped when the advance limit stops it), S_W1 and S_OUT; a result not taken stalls it.
// A deadline or period write recomputes the deadline (S_MUL), a dup period write the
// residue (S_DIV); not ready meanwhile. Sync active-low reset clears control state.
`timescale 1ns / 1ps
module jitter_buffer_playout_nack #(
    parameter int MAX_ADVANCES = jbpn_pkg::MAX_ADVANCES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // seq[31:0], payload_handle[47:32], now_us[95:48]
    input  logic [95:0]  s_axis_tdata,
    // opcode
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_seq[31:0], out_handle[47:32], wait_us[67:48], zero fill [71:68]
    output logic [71:0]  m_axis_tdata,
    // kind
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    localparam int WINDOW = jbpn_pkg::WINDOW_DEF;
    localparam int SW = $clog2(WINDOW);
    localparam int AW = $clog2(MAX_ADVANCES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_ARR, S_RD, S_STEP, S_N1, S_N2, S_N3, S_W1, S_OUT,
        S_MUL, S_DIV
    } t_state;

    jbpn_pkg::t_cfg     w_cfg;
    jbpn_pkg::t_cfg_evt w_evt;

    jbpn_regs u_regs (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .o_cfg(w_cfg), .o_evt(w_evt)
    );

    t_state         r_state, r_ret;
    logic [31:0]    r_exp;
    logic [47:0]    r_dl;
    logic [15:0]    r_res;
    logic [WINDOW-1:0] r_vld;
    logic [15:0]    r_mem [WINDOW];
    logic [15:0]    r_rdh;
    logic [31:0]    r_lnn;
    logic [47:0]    r_lnt;
    logic [3:0]     r_ncnt;
    logic           r_op;
    logic [31:0]    r_seq;
    logic [15:0]    r_hnd;
    logic [47:0]    r_now;
    logic [AW-1:0]  r_steps;
    logic           r_okn;
    logic           r_okt;
    logic           r_ovld;
    logic [2:0]     r_okind;
    logic [31:0]    r_oseq;
    logic [15:0]    r_ohnd;
    logic [19:0]    r_owait;
    logic           r_olast;
    logic [52:0]    r_acc;
    logic [5:0]     r_cnt;
    logic [31:0]    r_q;
    logic [16:0]    r_rem;
    logic           r_pmul, r_pdiv;

    logic [15:0]    w_per;
    logic [SW-1:0]  w_es;
    logic [48:0]    w_add;
    logic [16:0]    w_rsh;
    logic [32:0]    w_diff;
    logic [48:0]    w_sum;
    logic           w_flag_mul, w_flag_div;

    assign w_per  = (w_cfg.dup_len == 16'd0) ? 16'd1 : w_cfg.dup_len;
    assign w_es   = r_exp[SW-1:0];
    assign w_diff = {1'b0, r_seq} - {1'b0, r_exp};
    assign w_add  = {1'b0, r_dl} + {29'd0, w_cfg.frame_period};
    assign w_sum  = {1'b0, r_now} + {29'd0, w_cfg.nack_rtt};
    assign w_rsh  = {r_rem[15:0], r_q[31]};
    assign w_flag_mul = w_evt.wr &&
        (w_evt.idx == jbpn_pkg::R_FIRST || w_evt.idx == jbpn_pkg::R_PERIOD);
    assign w_flag_div = w_evt.wr && w_evt.idx == jbpn_pkg::R_DUPP;

    assign s_axis_tready = (r_state == S_IDLE) && !r_pmul && !r_pdiv;
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {4'd0, r_owait, r_ohnd, r_oseq};
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;

    always_ff @(posedge i_clk) begin
        if (r_state == S_ARR && s_axis_tready == 1'b0 && !r_op &&
            !(r_seq < r_exp) && w_diff[31:0] < 32'(WINDOW) && !r_vld[r_seq[SW-1:0]]) begin
            r_mem[r_seq[SW-1:0]] <= r_hnd;
        end
        r_rdh <= r_mem[w_es];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_exp   <= 32'd0;
            r_dl    <= 48'd0;
            r_res   <= 16'd0;
            r_vld   <= '0;
            r_lnn   <= 32'hFFFF_FFFF;
            r_lnt   <= 48'd0;
            r_ncnt  <= 4'd0;
            r_ovld  <= 1'b0;
            r_pmul  <= 1'b0;
            r_pdiv  <= 1'b0;
        end else begin
            if (w_flag_mul) r_pmul <= 1'b1;
            if (w_flag_div) r_pdiv <= 1'b1;
            if (r_ovld && m_axis_tready) r_ovld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (r_pmul && !w_flag_mul && !w_flag_div) begin
                        r_pmul  <= 1'b0;
                        r_acc   <= {5'd0, w_cfg.first_deadline};
                        r_q     <= r_exp;
                        r_cnt   <= 6'd0;
                        r_state <= S_MUL;
                    end else if (r_pdiv && !w_flag_mul && !w_flag_div) begin
                        r_pdiv  <= 1'b0;
                        r_q     <= r_exp;
                        r_rem   <= 17'd0;
                        r_cnt   <= 6'd0;
                        r_state <= S_DIV;
                    end else if (s_axis_tvalid && s_axis_tready) begin
                        r_op    <= s_axis_tuser;
                        r_seq   <= s_axis_tdata[31:0];
                        r_hnd   <= s_axis_tdata[47:32];
                        r_now   <= s_axis_tdata[95:48];
                        r_steps <= '0;
                        r_state <= s_axis_tuser ? S_RD : S_ARR;
                    end
                end
                S_MUL: begin
                    // shift-add from the top bit of the sequence
                    if (r_q[31]) begin
                        r_acc <= r_acc + ({33'd0, w_cfg.frame_period} << (31 - r_cnt[4:0]));
                    end
                    r_q   <= {r_q[30:0], 1'b0};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd31) r_state <= S_W1;
                    r_ret <= S_MUL;
                end
                S_DIV: begin
                    if (w_rsh >= {1'b0, w_per}) r_rem <= w_rsh - {1'b0, w_per};
                    else                        r_rem <= w_rsh;
                    r_q   <= {r_q[30:0], 1'b0};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd31) begin
                        r_res   <= (w_rsh >= {1'b0, w_per}) ?
                                   16'(w_rsh - {1'b0, w_per}) : w_rsh[15:0];
                        r_state <= S_IDLE;
                    end
                end
                S_ARR: begin
                    if (!r_ovld) begin
                        r_oseq  <= r_seq;
                        r_ohnd  <= 16'd0;
                        r_owait <= 20'd0;
                        r_olast <= 1'b1;
                        r_ovld  <= 1'b1;
                        r_state <= S_IDLE;
                        priority if (r_seq < r_exp) begin
                            r_okind <= jbpn_pkg::K_STALE;
                        end else if (w_diff[31:0] >= 32'(WINDOW)) begin
                            r_okind <= jbpn_pkg::K_OOW;
                        end else if (r_vld[r_seq[SW-1:0]]) begin
                            r_okind <= jbpn_pkg::K_STALE;
                        end else begin
                            r_okind <= jbpn_pkg::K_ACC;
                            r_vld[r_seq[SW-1:0]] <= 1'b1;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    if (r_steps == AW'(MAX_ADVANCES)) begin
                        r_okn   <= 1'b0;
                        r_state <= S_W1;
                        r_ret   <= S_STEP;
                    end else if (r_vld[w_es] || r_now >= r_dl) begin
                        if (!r_ovld || m_axis_tready) begin
                            r_okind <= r_vld[w_es] ? jbpn_pkg::K_PLAY : jbpn_pkg::K_LOST;
                            r_oseq  <= r_exp;
                            r_ohnd  <= r_vld[w_es] ? r_rdh : 16'd0;
                            r_owait <= 20'd0;
                            r_olast <= 1'b0;
                            r_ovld  <= 1'b1;
                            r_vld[w_es] <= 1'b0;
                            r_exp   <= r_exp + 32'd1;
                            r_ncnt  <= 4'd0;
                            r_steps <= r_steps + AW'(1);
                            if (r_exp == 32'hFFFF_FFFF) begin
                                r_dl  <= w_cfg.first_deadline;
                                r_res <= 16'd0;
                            end else begin
                                r_dl  <= w_add[48] ? jbpn_pkg::M48 : w_add[47:0];
                                r_res <= ({1'b0, r_res} + 17'd1 >= {1'b0, w_per}) ?
                                         16'd0 : r_res + 16'd1;
                            end
                            r_state <= S_RD;
                        end
                    end else begin
                        r_state <= S_N1;
                    end
                end
                S_N1: begin
                    r_okn <= (r_res >= w_cfg.dup_floor) && (w_sum < {1'b0, r_dl}) &&
                             (r_ncnt < w_cfg.max_nacks);
                    r_okt <= (r_now >= r_lnt) &&
                             (r_now - r_lnt >= {28'd0, w_cfg.nack_interval});
                    r_state <= S_N2;
                end
                S_N2: begin
                    if (r_okn && r_lnn != r_exp) begin
                        r_lnn  <= r_exp;
                        r_ncnt <= 4'd0;
                    end
                    r_state <= S_N3;
                end
                S_N3: begin
                    if (r_okn && r_okt) begin
                        if (!r_ovld || m_axis_tready) begin
                            r_okind <= jbpn_pkg::K_NACK;
                            r_oseq  <= r_exp;
                            r_ohnd  <= 16'd0;
                            r_owait <= 20'd0;
                            r_olast <= 1'b0;
                            r_ovld  <= 1'b1;
                            r_lnt   <= r_now;
                            r_ncnt  <= r_ncnt + 4'd1;
                            r_state <= S_W1;
                            r_ret   <= S_N3;
                        end
                    end else begin
                        r_state <= S_W1;
                        r_ret   <= S_N3;
                    end
                end
                S_W1: begin
                    if (r_ret == S_MUL) begin
                        r_dl    <= (r_acc > {5'd0, jbpn_pkg::M48}) ?
                                   jbpn_pkg::M48 : r_acc[47:0];
                        r_state <= S_IDLE;
                    end else begin
                        r_acc   <= {5'd0, r_dl} - {5'd0, r_now};
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovld || m_axis_tready) begin
                        r_okind <= jbpn_pkg::K_DONE;
                        r_oseq  <= r_exp;
                        r_ohnd  <= 16'd0;
                        r_owait <= (r_dl <= r_now) ? 20'd0 :
                                   (r_acc[47:0] > {28'd0, w_cfg.wait_cap}) ?
                                   w_cfg.wait_cap : r_acc[19:0];
                        r_olast <= 1'b1;
                        r_ovld  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
